// ----- rtl/assert_macros.svh -----
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define FBPA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define FBPA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/fbpa_pkg.sv -----
package fbpa_pkg;

  localparam logic [2:0] MODE_ALLOC = 3'd0;
  localparam logic [2:0] MODE_FREE  = 3'd1;
  localparam logic [2:0] MODE_WRITE = 3'd2;
  localparam logic [2:0] MODE_READ  = 3'd3;
  localparam logic [2:0] MODE_USAGE = 3'd4;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_PARAM    = 3'd1;
  localparam logic [2:0] ST_NOFREE   = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_CORRUPT  = 3'd4;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_FILL_BYTE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHECK_OVF = 2'd1;

  localparam logic [7:0] FILL_RESET = 8'h00;

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] owner;
    logic [3:0]  block_index;
    logic [5:0]  byte_offset;
    logic [7:0]  write_byte;
  } fbpa_in_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] granted_block;
    logic [7:0] read_value;
    logic [6:0] used_bytes;
    logic [4:0] free_blocks;
  } fbpa_out_t;

endpackage

// ----- rtl/fixed_block_pool_allocator.sv -----
// One item at a time; the next is taken in the strobe cycle. Alloc, free and usage scan the
// tags serially; alloc with check and usage then walk the block's bytes, and free refills
// them. How long an item takes is set by the serial tag scan and the byte-by-byte walk.
// Reset: a clearing pass over every byte address (busy high) zeroes tags and bytes.
// Results are strobed for one cycle; the receiver cannot stall.
module fixed_block_pool_allocator #(
  parameter int POOL_BLOCKS = 16,
  parameter int BLOCK_BYTES = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  fbpa_pkg::fbpa_in_t                  in_data,
  output logic                                out_strobe,
  output fbpa_pkg::fbpa_out_t                 out_data,
  input  logic                                cfg_we,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fbpa_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  import fbpa_pkg::*;

  localparam int TOTAL  = POOL_BLOCKS * BLOCK_BYTES;
  localparam int BA_W   = (TOTAL > 1) ? $clog2(TOTAL) : 1;
  localparam int TIDX_W = (POOL_BLOCKS > 1) ? $clog2(POOL_BLOCKS) : 1;
  localparam int KW     = $clog2(BLOCK_BYTES + 1);
  localparam int FW     = $clog2(POOL_BLOCKS + 1);
  localparam int CALC_W = BA_W + 15;

  localparam logic [3:0] S_CLR    = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_DISP   = 4'd2;
  localparam logic [3:0] S_TSCAN  = 4'd3;
  localparam logic [3:0] S_BWALK  = 4'd4;
  localparam logic [3:0] S_BFILL  = 4'd5;
  localparam logic [3:0] S_RDWAIT = 4'd6;
  localparam logic [3:0] S_BEND   = 4'd7;
  localparam logic [3:0] S_FIN    = 4'd8;

  logic [3:0]        state_r, state_nxt;
  fbpa_in_t          req_r, req_nxt;
  logic [BA_W-1:0]   clr_r, clr_nxt;
  logic [TIDX_W:0]   ti_r, ti_nxt;
  logic [TIDX_W-1:0] tk_r, tk_nxt;
  logic              tchk_r, tchk_nxt;
  logic [TIDX_W-1:0] blk_r, blk_nxt;
  logic [BA_W-1:0]   ba_r, ba_nxt;
  logic [KW-1:0]     kk_r, kk_nxt;
  logic              bchk_r, bchk_nxt;
  logic [KW-1:0]     used_r, used_nxt;
  logic [2:0]        status_r, status_nxt;
  logic [7:0]        read_r, read_nxt;
  logic [FW-1:0]     free_cnt_r, free_cnt_nxt;
  logic [7:0]        fill_r;
  logic              check_r;
  logic              out_strobe_r, out_strobe_nxt;
  fbpa_out_t         out_r, out_nxt;

  logic              tag_we;
  logic [TIDX_W-1:0] tag_waddr;
  logic [15:0]       tag_wdata;
  logic [15:0]       tag_q;
  logic              b_we;
  logic [BA_W-1:0]   b_waddr;
  logic [7:0]        b_wdata;
  logic [BA_W-1:0]   b_raddr;
  logic [7:0]        b_q;

  logic [CALC_W-1:0] req_calc;
  logic [CALC_W-1:0] base_calc;
  logic              req_addr_ok;
  logic              owner_mode;
  logic [15:0]       scan_key;

  fbpa_ram #(.WIDTH(16), .DEPTH(POOL_BLOCKS), .ADDR_W(TIDX_W)) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (tag_waddr),
    .wdata (tag_wdata),
    .raddr (ti_r[TIDX_W-1:0]),
    .rdata (tag_q)
  );

  fbpa_ram #(.WIDTH(8), .DEPTH(TOTAL), .ADDR_W(BA_W)) u_byte_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (b_wdata),
    .raddr (b_raddr),
    .rdata (b_q)
  );

  assign req_calc = CALC_W'(req_r.block_index) * CALC_W'(BLOCK_BYTES)
                  + CALC_W'(req_r.byte_offset);
  assign base_calc = CALC_W'(tk_r) * CALC_W'(BLOCK_BYTES);
  assign req_addr_ok = (9'(req_r.block_index) < 9'(POOL_BLOCKS))
                    && (11'(req_r.byte_offset) < 11'(BLOCK_BYTES));
  assign owner_mode = (req_r.mode == MODE_ALLOC) || (req_r.mode == MODE_FREE)
                   || (req_r.mode == MODE_USAGE);
  assign scan_key = (req_r.mode == MODE_ALLOC) ? 16'd0 : req_r.owner;

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_data   = out_r;

  always_comb begin
    state_nxt      = state_r;
    req_nxt        = req_r;
    clr_nxt        = clr_r;
    ti_nxt         = ti_r;
    tk_nxt         = tk_r;
    tchk_nxt       = tchk_r;
    blk_nxt        = blk_r;
    ba_nxt         = ba_r;
    kk_nxt         = kk_r;
    bchk_nxt       = bchk_r;
    used_nxt       = used_r;
    status_nxt     = status_r;
    read_nxt       = read_r;
    free_cnt_nxt   = free_cnt_r;
    out_strobe_nxt = 1'b0;
    out_nxt        = out_r;
    tag_we         = 1'b0;
    tag_waddr      = tk_r;
    tag_wdata      = 16'd0;
    b_we           = 1'b0;
    b_waddr        = ba_r;
    b_wdata        = fill_r;
    b_raddr        = ba_r;

    case (state_r)
      S_CLR: begin
        b_we    = 1'b1;
        b_waddr = clr_r;
        b_wdata = FILL_RESET;
        if (CALC_W'(clr_r) < CALC_W'(POOL_BLOCKS)) begin
          tag_we    = 1'b1;
          tag_waddr = clr_r[TIDX_W-1:0];
        end
        clr_nxt = clr_r + 1'b1;
        if (clr_r == BA_W'(TOTAL - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          req_nxt   = in_data;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        status_nxt = ST_OK;
        read_nxt   = 8'd0;
        used_nxt   = '0;
        blk_nxt    = '0;
        ti_nxt     = '0;
        tchk_nxt   = 1'b0;
        state_nxt  = S_FIN;
        if (owner_mode) begin
          if (req_r.owner == 16'd0) begin
            status_nxt = ST_PARAM;
          end else begin
            state_nxt = S_TSCAN;
          end
        end else if (req_r.mode == MODE_WRITE) begin
          if (req_addr_ok) begin
            b_we    = 1'b1;
            b_waddr = req_calc[BA_W-1:0];
            b_wdata = req_r.write_byte;
          end else begin
            status_nxt = ST_PARAM;
          end
        end else if (req_r.mode == MODE_READ) begin
          if (req_addr_ok) begin
            b_raddr   = req_calc[BA_W-1:0];
            state_nxt = S_RDWAIT;
          end else begin
            status_nxt = ST_PARAM;
          end
        end else begin
          status_nxt = ST_PARAM;
        end
      end
      S_RDWAIT: begin
        read_nxt  = b_q;
        state_nxt = S_FIN;
      end
      S_TSCAN: begin
        // tag_q holds entry tk_r when tchk_r is set; next entry is issued meanwhile
        if (tchk_r && (tag_q == scan_key)) begin
          blk_nxt  = tk_r;
          ba_nxt   = base_calc[BA_W-1:0];
          kk_nxt   = '0;
          bchk_nxt = 1'b0;
          case (req_r.mode)
            MODE_ALLOC: begin
              tag_we       = 1'b1;
              tag_wdata    = req_r.owner;
              free_cnt_nxt = free_cnt_r - 1'b1;
              state_nxt    = check_r ? S_BWALK : S_FIN;
            end
            MODE_FREE: begin
              tag_we       = 1'b1;
              free_cnt_nxt = free_cnt_r + 1'b1;
              state_nxt    = S_BFILL;
            end
            default: begin
              state_nxt = S_BWALK;
            end
          endcase
        end else if (tchk_r && (tk_r == TIDX_W'(POOL_BLOCKS - 1))) begin
          status_nxt = (req_r.mode == MODE_ALLOC) ? ST_NOFREE : ST_NOTFOUND;
          state_nxt  = S_FIN;
        end else if (ti_r < (TIDX_W+1)'(POOL_BLOCKS)) begin
          tchk_nxt = 1'b1;
          tk_nxt   = ti_r[TIDX_W-1:0];
          ti_nxt   = ti_r + 1'b1;
        end else begin
          tchk_nxt = 1'b0;
        end
      end
      S_BWALK: begin
        if (bchk_r && (b_q != fill_r)) begin
          used_nxt = used_r + 1'b1;
        end
        if (kk_r != KW'(BLOCK_BYTES)) begin
          bchk_nxt = 1'b1;
          ba_nxt   = ba_r + 1'b1;
          kk_nxt   = kk_r + 1'b1;
        end else begin
          bchk_nxt  = 1'b0;
          state_nxt = S_BEND;
        end
      end
      S_BFILL: begin
        b_we   = 1'b1;
        ba_nxt = ba_r + 1'b1;
        kk_nxt = kk_r + 1'b1;
        if (kk_r == KW'(BLOCK_BYTES - 1)) begin
          state_nxt = S_FIN;
        end
      end
      S_BEND: begin
        if ((req_r.mode == MODE_ALLOC) && (used_r != '0)) begin
          status_nxt = ST_CORRUPT;
        end
        state_nxt = S_FIN;
      end
      S_FIN: begin
        out_strobe_nxt        = 1'b1;
        out_nxt.status        = status_r;
        out_nxt.granted_block = (req_r.mode == MODE_ALLOC) ? 4'(blk_r) : 4'd0;
        out_nxt.read_value    = read_r;
        if (req_r.mode == MODE_USAGE) begin
          out_nxt.used_bytes = (32'(used_r) > 32'd127) ? 7'd127 : 7'(used_r);
        end else begin
          out_nxt.used_bytes = 7'd0;
        end
        out_nxt.free_blocks = (32'(free_cnt_r) > 32'd31) ? 5'd31 : 5'(free_cnt_r);
        state_nxt           = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      clr_r        <= '0;
      free_cnt_r   <= FW'(POOL_BLOCKS);
      out_strobe_r <= 1'b0;
      fill_r       <= FILL_RESET;
      check_r      <= 1'b1;
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      free_cnt_r   <= free_cnt_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_we && (cfg_index == CFG_FILL_BYTE)) begin
        fill_r <= cfg_wdata;
      end
      if (cfg_we && (cfg_index == CFG_CHECK_OVF)) begin
        check_r <= cfg_wdata[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r    <= req_nxt;
    ti_r     <= ti_nxt;
    tk_r     <= tk_nxt;
    tchk_r   <= tchk_nxt;
    blk_r    <= blk_nxt;
    ba_r     <= ba_nxt;
    kk_r     <= kk_nxt;
    bchk_r   <= bchk_nxt;
    used_r   <= used_nxt;
    status_r <= status_nxt;
    read_r   <= read_nxt;
    out_r    <= out_nxt;
  end

endmodule

// ----- rtl/fbpa_ram.sv -----
module fbpa_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/fbpa_checker.sv -----
`include "assert_macros.svh"

module fbpa_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_strobe,
  input fbpa_pkg::fbpa_out_t out_data
);

  import fbpa_pkg::*;

  // a result beat only closes an item that was in progress
  `FBPA_ASSERT_IMP(a_strobe_after_busy, out_strobe, $past(busy), "result beat without item in flight")

  // an accepted item holds busy and produces no beat in the next cycle
  `FBPA_ASSERT_NXT(a_accept_busy, start && !busy, busy && !out_strobe, "accept did not start work")

  // every item passes through dispatch and finish states so beats never come back to back
  `FBPA_ASSERT_NXT(a_single_beat, out_strobe, !out_strobe, "result beat repeated")

  // failed items grant nothing and report no usage
  `FBPA_ASSERT_IMP(a_fail_clean, out_strobe && out_data.status != ST_OK && out_data.status != ST_CORRUPT, out_data.granted_block == 4'd0 && out_data.used_bytes == 7'd0, "failed item carries data")

endmodule

bind fixed_block_pool_allocator fbpa_checker u_fbpa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_data   (out_data)
);

// ----- tb/fixed_block_pool_allocator_test.sv -----
`timescale 1ns / 100ps

module fixed_block_pool_allocator_test;
  import fbpa_pkg::*;

  localparam int NUM_BLOCKS    = 16;
  localparam int NUM_BYTES     = 64;
  localparam int IDLE_PCT      = 21;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 120;
  // clearing pass after reset plus the longest item and sender gaps, with margin
  localparam int STALL_LIMIT   = 6000;
  localparam int PHASE_BEATS   = 116;

  typedef enum logic [1:0] {OP_BEAT, OP_CFG, OP_HOLD} op_kind_t;

  typedef struct {
    op_kind_t               kind;
    fbpa_in_t               beat;
    logic [CFG_IDX_W-1:0]   reg_idx;
    logic [CFG_DATA_W-1:0]  reg_val;
  } pool_op_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  fbpa_in_t              in_data = '0;
  logic                  out_strobe;
  fbpa_out_t             out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  pool_op_t    pending_ops[$];
  fbpa_out_t   expected_results[$];
  int unsigned failures = 0;
  int unsigned gap_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned beats_taken = 0;
  int unsigned stall_cycles = 0;

  // shadow of the pool
  logic [15:0] tag_shadow  [NUM_BLOCKS];
  logic [7:0]  byte_shadow [NUM_BLOCKS][NUM_BYTES];
  logic [7:0]  fill_shadow = FILL_RESET;
  logic        check_shadow = 1'b1;
  logic [15:0] owner_set [8];

  fixed_block_pool_allocator #(
    .POOL_BLOCKS (NUM_BLOCKS),
    .BLOCK_BYTES (NUM_BYTES)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    for (int b = 0; b < NUM_BLOCKS; b++) begin
      tag_shadow[b] = '0;
      for (int k = 0; k < NUM_BYTES; k++) byte_shadow[b][k] = FILL_RESET;
    end
  end

  // lowest block carrying the tag, -1 if none
  function automatic int find_tagged(logic [15:0] tag);
    for (int b = 0; b < NUM_BLOCKS; b++)
      if (tag_shadow[b] == tag) return b;
    return -1;
  endfunction

  function automatic int dirty_bytes(int blk);
    int n;
    n = 0;
    for (int k = 0; k < NUM_BYTES; k++)
      if (byte_shadow[blk][k] != fill_shadow) n++;
    return n;
  endfunction

  function automatic fbpa_out_t predict_pool(fbpa_in_t b);
    fbpa_out_t r;
    int blk;
    int nfree;
    r = '0;
    r.status = ST_OK;
    case (b.mode)
      MODE_ALLOC, MODE_FREE, MODE_USAGE: begin
        if (b.owner == 16'h0000) begin
          r.status = ST_PARAM;
        end else if (b.mode == MODE_ALLOC) begin
          blk = find_tagged(16'h0000);
          if (blk < 0) begin
            r.status = ST_NOFREE;
          end else begin
            tag_shadow[blk] = b.owner;
            r.granted_block = blk[3:0];
            // block is granted even when found dirty
            if (check_shadow && dirty_bytes(blk) != 0) r.status = ST_CORRUPT;
          end
        end else begin
          blk = find_tagged(b.owner);
          if (blk < 0) begin
            r.status = ST_NOTFOUND;
          end else if (b.mode == MODE_FREE) begin
            for (int k = 0; k < NUM_BYTES; k++) byte_shadow[blk][k] = fill_shadow;
            tag_shadow[blk] = '0;
          end else begin
            r.used_bytes = 7'(dirty_bytes(blk));
          end
        end
      end
      MODE_WRITE: byte_shadow[b.block_index][b.byte_offset] = b.write_byte;
      MODE_READ:  r.read_value = byte_shadow[b.block_index][b.byte_offset];
      default:    r.status = ST_PARAM;
    endcase
    nfree = 0;
    for (int i = 0; i < NUM_BLOCKS; i++)
      if (tag_shadow[i] == 16'h0000) nfree++;
    r.free_blocks = 5'(nfree);
    return r;
  endfunction

  // sender
  always @(posedge clk) begin : drive_p
    logic took;
    logic cfg_go;
    logic steady;
    took   = start && !busy;
    cfg_go = 1'b0;
    steady = (beats_taken >= 250) && (beats_taken < 400);
    if (!rst_n) begin
      start        <= 1'b0;
      gap_left     <= 0;
      quiet_cycles <= 0;
    end else begin
      if (took) begin
        expected_results.push_back(predict_pool(in_data));
        beats_taken <= beats_taken + 1;
      end
      quiet_cycles <= (took || out_strobe) ? 0 : quiet_cycles + 1;
      if (start && !took) begin
        // beat still waiting on busy
      end else if (gap_left != 0) begin
        start    <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_ops.size() == 0) begin
        start <= 1'b0;
      end else if (pending_ops[0].kind == OP_BEAT) begin
        if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
          start    <= 1'b0;
          gap_left <= $urandom_range(0, 40);
        end else begin
          start   <= 1'b1;
          in_data <= pending_ops[0].beat;
          void'(pending_ops.pop_front());
        end
      end else begin
        start <= 1'b0;
        if (!busy && expected_results.size() == 0 && quiet_cycles >= SETTLE_CYCLES) begin
          if (pending_ops[0].kind == OP_CFG) begin
            cfg_go    = 1'b1;
            cfg_index <= pending_ops[0].reg_idx;
            cfg_wdata <= pending_ops[0].reg_val;
            if (pending_ops[0].reg_idx == CFG_FILL_BYTE)
              fill_shadow = pending_ops[0].reg_val;
            else if (pending_ops[0].reg_idx == CFG_CHECK_OVF)
              check_shadow = pending_ops[0].reg_val[0];
          end
          void'(pending_ops.pop_front());
        end
      end
    end
    cfg_we <= cfg_go;
  end

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endtask

  // result checker
  always @(posedge clk) begin : watch_p
    fbpa_out_t want;
    if (rst_n && out_strobe) begin
      if (expected_results.size() == 0) begin
        $error("result beat with nothing expected");
        failures++;
      end else begin
        want = expected_results.pop_front();
        check_field("status", 16'(want.status), 16'(out_data.status));
        check_field("granted_block", 16'(want.granted_block), 16'(out_data.granted_block));
        check_field("read_value", 16'(want.read_value), 16'(out_data.read_value));
        check_field("used_bytes", 16'(want.used_bytes), 16'(out_data.used_bytes));
        check_field("free_blocks", 16'(want.free_blocks), 16'(out_data.free_blocks));
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_strobe) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic push_beat(logic [2:0] mode, logic [15:0] owner, logic [3:0] blk,
                           logic [5:0] offs, logic [7:0] wb);
    pool_op_t op;
    op.kind                 = OP_BEAT;
    op.beat.mode            = mode;
    op.beat.owner           = owner;
    op.beat.block_index     = blk;
    op.beat.byte_offset     = offs;
    op.beat.write_byte      = wb;
    op.reg_idx              = '0;
    op.reg_val              = '0;
    pending_ops.push_back(op);
  endtask

  task automatic push_ctl(op_kind_t kind, logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
    pool_op_t op;
    op.kind    = kind;
    op.beat    = '0;
    op.reg_idx = idx;
    op.reg_val = val;
    pending_ops.push_back(op);
  endtask

  function automatic logic [15:0] pick_owner();
    if ($urandom_range(0, 9) == 0) return 16'($urandom);
    return owner_set[$urandom_range(0, 7)];
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 2))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // alloc_pct steers the pool toward full or toward empty
  task automatic push_random(int alloc_pct);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < alloc_pct) begin
      push_beat(MODE_ALLOC, pick_owner(), 4'($urandom), 6'($urandom), 8'($urandom));
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 25)
        push_beat(MODE_FREE, pick_owner(), 4'($urandom), 6'($urandom), 8'($urandom));
      else if (pick < 55)
        push_beat(MODE_WRITE, 16'($urandom), 4'($urandom), 6'($urandom), pick_byte());
      else if (pick < 75)
        push_beat(MODE_READ, 16'($urandom), 4'($urandom), 6'($urandom), 8'($urandom));
      else if (pick < 95)
        push_beat(MODE_USAGE, pick_owner(), 4'($urandom), 6'($urandom), 8'($urandom));
      else if (pick < 97)
        push_beat(3'($urandom_range(0, 1)) == 0 ? MODE_ALLOC : MODE_USAGE, 16'h0000,
                  4'($urandom), 6'($urandom), 8'($urandom));
      else
        push_beat(MODE_USAGE + 3'($urandom_range(1, 3)), 16'($urandom), 4'($urandom),
                  6'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    logic [7:0] phase_fill [5];
    logic       phase_chk  [5];
    int         phase_alloc[5];

    owner_set[0] = 16'hFFFF;
    owner_set[1] = 16'h0001;
    owner_set[2] = 16'h8000;
    owner_set[3] = 16'h00FF;
    for (int i = 4; i < 8; i++) owner_set[i] = 16'($urandom_range(1, 65535));

    // directed: fill 0, overflow check on
    push_beat(MODE_ALLOC, 16'h0000, 4'd0, 6'd0, 8'h00);
    push_beat(MODE_FREE,  16'h0000, 4'd0, 6'd0, 8'h00);
    push_beat(MODE_USAGE, 16'h0000, 4'd0, 6'd0, 8'h00);
    push_beat(MODE_FREE,  16'h1234, 4'd0, 6'd0, 8'h00);
    push_beat(MODE_USAGE, 16'h1234, 4'd0, 6'd0, 8'h00);
    push_beat(MODE_ALLOC, 16'hFFFF, 4'd0, 6'd0, 8'h00);
    push_beat(MODE_ALLOC, 16'h0001, 4'd0, 6'd0, 8'h00);
    push_beat(MODE_ALLOC, 16'hFFFF, 4'd0, 6'd0, 8'h00);   // duplicate owner
    push_beat(MODE_WRITE, 16'h0000, 4'd0, 6'd0, 8'hFF);
    push_beat(MODE_WRITE, 16'h0000, 4'd0, 6'd63, 8'h80);
    push_beat(MODE_WRITE, 16'h0000, 4'd15, 6'd63, 8'hA5);  // into a free block
    push_beat(MODE_READ,  16'h0000, 4'd0, 6'd0, 8'h00);
    push_beat(MODE_READ,  16'h0000, 4'd15, 6'd63, 8'h00);
    push_beat(MODE_READ,  16'h0000, 4'd7, 6'd32, 8'h00);
    push_beat(MODE_USAGE, 16'hFFFF, 4'd0, 6'd0, 8'h00);
    push_beat(MODE_FREE,  16'hFFFF, 4'd0, 6'd0, 8'h00);
    push_beat(MODE_USAGE, 16'hFFFF, 4'd0, 6'd0, 8'h00);   // now hits the second copy
    push_beat(MODE_WRITE, 16'h0000, 4'd0, 6'd5, 8'h01);
    push_beat(MODE_ALLOC, 16'h8000, 4'd0, 6'd0, 8'h00);   // dirty block: corrupted
    push_beat(MODE_USAGE + 3'd1, 16'h0001, 4'd0, 6'd0, 8'h00);
    push_beat(MODE_USAGE + 3'd3, 16'h0001, 4'd0, 6'd0, 8'h00);
    push_beat(MODE_FREE,  16'h0001, 4'd0, 6'd0, 8'h00);
    push_beat(MODE_READ,  16'h0000, 4'd0, 6'd5, 8'h00);

    phase_fill[0] = 8'hFF;               phase_chk[0] = 1'b0; phase_alloc[0] = 45;
    phase_fill[1] = 8'h00;               phase_chk[1] = 1'b1; phase_alloc[1] = 30;
    phase_fill[2] = 8'($urandom);        phase_chk[2] = 1'b1; phase_alloc[2] = 60;
    phase_fill[3] = 8'h5A;               phase_chk[3] = 1'b0; phase_alloc[3] = 15;
    phase_fill[4] = 8'hFF;               phase_chk[4] = 1'b1; phase_alloc[4] = 35;

    for (int p = 0; p < 5; p++) begin
      push_ctl(OP_CFG, CFG_FILL_BYTE, phase_fill[p]);
      push_ctl(OP_CFG, CFG_CHECK_OVF, {7'd0, phase_chk[p]});
      for (int n = 0; n < PHASE_BEATS; n++) begin
        if (n == PHASE_BEATS / 2) push_ctl(OP_HOLD, '0, '0);
        push_random(phase_alloc[p]);
      end
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_ops.size() != 0 || expected_results.size() != 0 || start)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
